>>> design/chip8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_pkg
// Shared constants and codes of the chip8 instruction core.
// ----------------------------------------------------------------------------
package chip8_pkg;

  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned ScreenW    = 64;
  localparam int unsigned ScreenH    = 32;
  localparam int unsigned Pixels     = ScreenW * ScreenH;
  localparam int unsigned AddrW      = 12;
  localparam int unsigned PixW       = $clog2(Pixels);

  localparam logic [AddrW-1:0] StartReset = 12'h200;
  localparam logic [15:0]      OpCls      = 16'h00E0;
  localparam logic [15:0]      OpRet      = 16'h00EE;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_RESTART = 3'd1,
    CMD_EXEC    = 3'd2,
    CMD_READ    = 3'd3,
    CMD_PIXEL   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_STACK   = 2'd2
  } status_e;

endpackage

>>> design/chip8_instruction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core
// Sequenced chip8 interpreter core; state kept in main, register, stack and
// frame buffer rams.
// Execute fetches the opcode and vx, vy, then runs it; clear screen, draw,
//   decimal store and register block moves step through the rams with one
//   ram access per cycle.
// Throughput: one word at a time; the next word is taken while a result waits.
// Reset: after rst_ni rises a clearing pass zeroes all rams before the first
//   word is accepted.
// ----------------------------------------------------------------------------
module chip8_instruction_core import chip8_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [11:0] program_counter_o,
  output logic [15:0] executed_opcode_o,
  output logic [7:0]  read_data_o
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WR, S_RDM, S_RDM2, S_RDP, S_RDP2,
    S_F0, S_F1, S_F2, S_F3, S_EXEC, S_RET, S_CLS,
    S_DROW, S_DBITS, S_DRD, S_DWR, S_DEND,
    S_F33, S_S55R, S_S55W, S_S65R, S_S65W, S_WF, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [11:0] pc_q, pc_d, i_q, i_d, start_q;
  logic [SPW-1:0] sp_q, sp_d;
  logic [7:0] dly_q, dly_d;
  logic [11:0] addr_q, addr_d, cnt_q, cnt_d;
  logic [7:0] wdat_q, wdat_d, vx_q, vx_d, vy_q, vy_d, bits_q, bits_d, rd_q, rd_d;
  logic [15:0] op_q, op_d;
  logic [1:0] st_q, st_d;
  logic [3:0] row_q, row_d;
  logic [2:0] col_q, col_d;
  logic hit_q, hit_d, flag_q, flag_d;
  logic ov_q, load;
  logic [1:0] status_q;
  logic [11:0] pco_q;
  logic [15:0] opo_q;
  logic [7:0] rdo_q;

  // ram ports
  logic mem_we, vr_we, stk_we, fb_we;
  logic [11:0] mem_wa, mem_ra;
  logic [7:0] mem_wd, mem_rd, vr_wd, vr_rd;
  logic [3:0] vr_wa, vr_ra;
  logic [SAW-1:0] stk_wa, stk_ra;
  logic [11:0] stk_wd, stk_rd;
  logic [PixW-1:0] fb_wa, fb_ra;
  logic fb_wd, fb_rd;

  chip8_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_wa), .wdata_i(mem_wd),
    .raddr_i(mem_ra), .rdata_o(mem_rd)
  );
  chip8_ram #(.Width(8), .Depth(16)) u_vreg (
    .clk_i, .we_i(vr_we), .waddr_i(vr_wa), .wdata_i(vr_wd),
    .raddr_i(vr_ra), .rdata_o(vr_rd)
  );
  chip8_ram #(.Width(12), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd)
  );
  chip8_ram #(.Width(1), .Depth(Pixels)) u_fb (
    .clk_i, .we_i(fb_we), .waddr_i(fb_wa), .wdata_i(fb_wd),
    .raddr_i(fb_ra), .rdata_o(fb_rd)
  );

  // decimal digits of vx
  logic [1:0] hund;
  logic [7:0] rem8, tens8, ones8;
  logic [15:0] prod;
  always_comb begin
    if (vx_q >= 8'd200) begin
      hund = 2'd2;
      rem8 = vx_q - 8'd200;
    end else if (vx_q >= 8'd100) begin
      hund = 2'd1;
      rem8 = vx_q - 8'd100;
    end else begin
      hund = 2'd0;
      rem8 = vx_q;
    end
    prod  = 16'(rem8) * 16'd205;
    tens8 = {4'b0, prod[14:11]};
    ones8 = rem8 - (tens8 << 3) - (tens8 << 1);
  end

  logic [PixW-1:0] pix;
  logic [4:0] py;
  logic [5:0] px;
  logic [8:0] sum9;
  logic [SPW-1:0] sp_ret, sp_call;
  assign py   = vy_q[4:0] + 5'(row_q);
  assign px   = vx_q[5:0] + 6'(col_q);
  assign pix  = {py, px};
  assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};
  assign sp_ret  = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - 1'b1;
  assign sp_call = (sp_q >= SPW'(STACK_DEPTH)) ? '0 : sp_q;

  assign load = (state_q == S_DONE) && (!ov_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    pc_d = pc_q; i_d = i_q; sp_d = sp_q; dly_d = dly_q;
    addr_d = addr_q; wdat_d = wdat_q; cnt_d = cnt_q;
    vx_d = vx_q; vy_d = vy_q; bits_d = bits_q; rd_d = rd_q;
    op_d = op_q; st_d = st_q; row_d = row_q; col_d = col_q;
    hit_d = hit_q; flag_d = flag_q;
    mem_we = 1'b0; mem_wa = addr_q; mem_wd = wdat_q; mem_ra = addr_q;
    vr_we = 1'b0; vr_wa = op_q[11:8]; vr_wd = '0; vr_ra = op_q[11:8];
    stk_we = 1'b0; stk_wa = sp_call[SAW-1:0]; stk_wd = pc_q;
    stk_ra = sp_ret[SAW-1:0];
    fb_we = 1'b0; fb_wa = pix; fb_wd = 1'b0; fb_ra = pix;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1; mem_wa = cnt_q; mem_wd = '0;
        fb_we = !cnt_q[11]; fb_wa = cnt_q[PixW-1:0];
        vr_we = (cnt_q < 12'd16); vr_wa = cnt_q[3:0];
        stk_we = (cnt_q < 12'(STACK_DEPTH)); stk_wa = cnt_q[SAW-1:0]; stk_wd = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 12'hFFF) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d = address_i; wdat_d = write_data_i;
          op_d = '0; rd_d = '0; st_d = ST_OK;
          unique case (command_i)
            CMD_WRITE:   state_d = S_WR;
            CMD_RESTART: begin
              pc_d = start_q;
              state_d = S_DONE;
            end
            CMD_EXEC:    state_d = S_F0;
            CMD_READ:    state_d = S_RDM;
            CMD_PIXEL:   state_d = address_i[11] ? S_DONE : S_RDP;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        state_d = S_DONE;
      end
      S_RDM: state_d = S_RDM2;
      S_RDM2: begin
        rd_d = mem_rd;
        state_d = S_DONE;
      end
      S_RDP: begin
        fb_ra = addr_q[PixW-1:0];
        state_d = S_RDP2;
      end
      S_RDP2: begin
        rd_d = {7'b0, fb_rd};
        state_d = S_DONE;
      end
      S_F0: begin
        mem_ra = pc_q;
        state_d = S_F1;
      end
      S_F1: begin
        op_d[15:8] = mem_rd;
        mem_ra = pc_q + 1'b1;
        vr_ra = mem_rd[3:0];
        state_d = S_F2;
      end
      S_F2: begin
        op_d[7:0] = mem_rd;
        vx_d = vr_rd;
        vr_ra = mem_rd[7:4];
        state_d = S_F3;
      end
      S_F3: begin
        vy_d = vr_rd;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        dly_d = (dly_q != '0) ? dly_q - 1'b1 : dly_q;
        pc_d = pc_q + 12'd2;
        state_d = S_DONE;
        unique case (op_q[15:12])
          4'h0: begin
            if (op_q == OpCls) begin
              cnt_d = '0;
              state_d = S_CLS;
            end else if (op_q == OpRet) begin
              if (sp_q == '0) st_d = ST_STACK;
              sp_d = sp_ret;
              state_d = S_RET;
            end else begin
              st_d = ST_UNKNOWN;
            end
          end
          4'h1: pc_d = op_q[11:0];
          4'h2: begin
            if (sp_q >= SPW'(STACK_DEPTH)) st_d = ST_STACK;
            stk_we = 1'b1;
            sp_d = sp_call + 1'b1;
            pc_d = op_q[11:0];
          end
          4'h3: if (vx_q == op_q[7:0]) pc_d = pc_q + 12'd4;
          4'h4: if (vx_q != op_q[7:0]) pc_d = pc_q + 12'd4;
          4'h5: if (vx_q == vy_q) pc_d = pc_q + 12'd4;
          4'h9: if (vx_q != vy_q) pc_d = pc_q + 12'd4;
          4'h6: begin
            vr_we = 1'b1; vr_wd = op_q[7:0];
          end
          4'h7: begin
            vr_we = 1'b1; vr_wd = vx_q + op_q[7:0];
          end
          4'h8: begin
            vr_we = 1'b1;
            state_d = S_WF;
            unique case (op_q[3:0])
              4'h0: begin vr_wd = vy_q; state_d = S_DONE; end
              4'h1: begin vr_wd = vx_q | vy_q; state_d = S_DONE; end
              4'h2: begin vr_wd = vx_q & vy_q; state_d = S_DONE; end
              4'h3: begin vr_wd = vx_q ^ vy_q; state_d = S_DONE; end
              4'h4: begin vr_wd = sum9[7:0]; flag_d = sum9[8]; end
              4'h5: begin vr_wd = vx_q - vy_q; flag_d = (vx_q >= vy_q); end
              4'h6: begin vr_wd = {1'b0, vx_q[7:1]}; flag_d = vx_q[0]; end
              4'h7: begin vr_wd = vy_q - vx_q; flag_d = (vy_q >= vx_q); end
              4'hE: begin vr_wd = {vx_q[6:0], 1'b0}; flag_d = vx_q[7]; end
              default: begin
                vr_we = 1'b0;
                st_d = ST_UNKNOWN;
                state_d = S_DONE;
              end
            endcase
          end
          4'hA: i_d = op_q[11:0];
          4'hD: begin
            row_d = '0; col_d = '0; hit_d = 1'b0;
            state_d = (op_q[3:0] == '0) ? S_DEND : S_DROW;
          end
          4'hF: begin
            cnt_d = '0;
            unique case (op_q[7:0])
              8'h07: begin vr_we = 1'b1; vr_wd = dly_q; end
              8'h1E: i_d = i_q + 12'(vx_q);
              8'h33: state_d = S_F33;
              8'h55: state_d = S_S55R;
              8'h65: state_d = S_S65R;
              default: st_d = ST_UNKNOWN;
            endcase
          end
          default: st_d = ST_UNKNOWN;
        endcase
      end
      S_RET: begin
        pc_d = stk_rd + 12'd2;
        state_d = S_DONE;
      end
      S_CLS: begin
        fb_we = 1'b1; fb_wa = cnt_q[PixW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 12'(Pixels - 1)) state_d = S_DONE;
      end
      S_DROW: begin
        mem_ra = i_q + 12'(row_q);
        state_d = S_DBITS;
      end
      S_DBITS: begin
        bits_d = mem_rd;
        col_d = '0;
        state_d = S_DRD;
      end
      S_DRD, S_DWR: begin
        if (state_q == S_DRD && bits_q[3'd7 - col_q]) begin
          state_d = S_DWR;
        end else begin
          if (state_q == S_DWR) begin
            fb_we = 1'b1; fb_wd = !fb_rd;
            hit_d = hit_q | fb_rd;
          end
          if (col_q != 3'd7) begin
            col_d = col_q + 1'b1;
            state_d = S_DRD;
          end else if (row_q + 1'b1 == op_q[3:0]) begin
            state_d = S_DEND;
          end else begin
            row_d = row_q + 1'b1;
            state_d = S_DROW;
          end
        end
      end
      S_DEND: begin
        vr_we = 1'b1; vr_wa = 4'hF; vr_wd = {7'b0, hit_q};
        state_d = S_DONE;
      end
      S_F33: begin
        mem_we = 1'b1; mem_wa = i_q + cnt_q;
        mem_wd = (cnt_q[1:0] == 2'd0) ? {6'b0, hund} :
                 (cnt_q[1:0] == 2'd1) ? tens8 : ones8;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd2) state_d = S_DONE;
      end
      S_S55R: begin
        vr_ra = cnt_q[3:0];
        state_d = S_S55W;
      end
      S_S55W: begin
        mem_we = 1'b1; mem_wa = i_q + cnt_q; mem_wd = vr_rd;
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q[3:0] == op_q[11:8]) ? S_DONE : S_S55R;
      end
      S_S65R: begin
        mem_ra = i_q + cnt_q;
        state_d = S_S65W;
      end
      S_S65W: begin
        vr_we = 1'b1; vr_wa = cnt_q[3:0]; vr_wd = mem_rd;
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q[3:0] == op_q[11:8]) ? S_DONE : S_S65R;
      end
      S_WF: begin
        vr_we = 1'b1; vr_wa = 4'hF; vr_wd = {7'b0, flag_q};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      pc_q     <= StartReset;
      i_q      <= '0;
      sp_q     <= '0;
      dly_q    <= '0;
      start_q  <= StartReset;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      i_q     <= i_d;
      sp_q    <= sp_d;
      dly_q   <= dly_d;
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d; wdat_q <= wdat_d; vx_q <= vx_d; vy_q <= vy_d;
    bits_q <= bits_d; rd_q <= rd_d; op_q <= op_d; st_q <= st_d;
    row_q <= row_d; col_q <= col_d; hit_q <= hit_d; flag_q <= flag_d;
    if (load) begin
      status_q <= st_q;
      pco_q    <= pc_q;
      opo_q    <= op_q;
      rdo_q    <= rd_q;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = ov_q;
  assign status_o          = status_q;
  assign program_counter_o = pco_q;
  assign executed_opcode_o = opo_q;
  assign read_data_o       = rdo_q;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer out of range");

  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && state_q == S_IDLE)
    else $error("result not presented after completion");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o && !out_valid_o)
    else $error("word taken during clearing pass");

endmodule

>>> design/chip8_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module chip8_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
